>>> rtl/core/utf8l_pkg.sv
// Shared types, constants and code point mapping for the UTF-8 to Latin-1 decoder.
package utf8l_pkg;

    // Lead byte classification masks and patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;

    localparam logic [7:0] REPL_CODE  = 8'h3F;
    localparam logic [7:0] SPACE_CODE = 8'h20;
    localparam logic [7:0] APOS_CODE  = 8'h27;
    localparam logic [7:0] QUOTE_CODE = 8'h22;
    localparam logic [7:0] DASH_CODE  = 8'h2D;
    localparam logic [7:0] ELLIP_CODE = 8'h85;

    localparam int CP_W = 21;

    // Pending continuation count
    localparam logic [1:0] PEND_NONE = 2'd0;

    // Result queue
    localparam int QUEUE_DEPTH = 3;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Number of results produced for one input word
    localparam logic [1:0] NUM_NONE = 2'd0;
    localparam logic [1:0] NUM_ONE  = 2'd1;
    localparam logic [1:0] NUM_TWO  = 2'd2;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_end;
        logic       last_of_run;
    } t_result;

    // Results handed from the decoder to the result queue
    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

    // Map a complete code point to a display code
    function automatic logic [7:0] map_codepoint(input logic [CP_W-1:0] cp);
        logic [7:0] code;
        code = REPL_CODE;
        if (cp >= 21'h0000A0 && cp <= 21'h0000FF) begin
            code = (cp == 21'h0000AD) ? SPACE_CODE : cp[7:0];
        end else if (cp >= 21'h002018 && cp <= 21'h00201B) begin
            code = APOS_CODE;
        end else if (cp >= 21'h00201C && cp <= 21'h00201F) begin
            code = QUOTE_CODE;
        end else if (cp == 21'h002013 || cp == 21'h002014) begin
            code = DASH_CODE;
        end else if (cp == 21'h002026) begin
            code = ELLIP_CODE;
        end else if (cp == 21'h002002 || cp == 21'h002003 || cp == 21'h002009) begin
            code = SPACE_CODE;
        end
        return code;
    endfunction

endpackage

>>> rtl/core/utf8l_if.sv
// Handshake interfaces for the byte input channel and the display code output channel.
interface utf8l_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source(output valid, output data_byte, output end_of_data, input ready);
    modport sink(input valid, input data_byte, input end_of_data, output ready);
endinterface

interface utf8l_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_end;
    logic       last_of_run;

    modport source(output valid, output char_code, output is_end, output last_of_run,
                   input ready);
    modport sink(input valid, input char_code, input is_end, input last_of_run,
                 output ready);
endinterface

>>> rtl/core/utf8l_dec.sv
// Input register, sequence state and single-pass UTF-8 decode for one byte.
module utf8l_dec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_data,
    input  logic                i_room,
    output utf8l_pkg::t_push    o_push
);

    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic                       r_in_end;
    logic [1:0]                 r_pending;
    logic [1:0]                 n_pending;
    logic [utf8l_pkg::CP_W-1:0] r_acc;
    logic [utf8l_pkg::CP_W-1:0] n_acc;
    logic [utf8l_pkg::CP_W-1:0] shifted;
    logic [1:0]                 dec_pending;
    logic                       consume;
    logic                       accept;
    utf8l_pkg::t_push           push;

    // Input word moves on to decode when the queue has room for two results
    assign consume = r_in_valid && i_room;
    assign o_ready = !r_in_valid || consume;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept || (r_in_valid && !consume);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_end_of_data;
        end
    end

    // Decode one word against the pending sequence
    assign shifted     = {r_acc[utf8l_pkg::CP_W-7:0], r_in_byte[5:0]};
    assign dec_pending = r_pending - 2'd1;

    always_comb begin
        n_pending   = r_pending;
        n_acc       = r_acc;
        push.num    = utf8l_pkg::NUM_NONE;
        push.first  = '{char_code: utf8l_pkg::REPL_CODE, is_end: 1'b0, last_of_run: 1'b1};
        push.second = '{char_code: 8'h00, is_end: 1'b1, last_of_run: 1'b1};
        priority if (r_in_end) begin
            n_pending = utf8l_pkg::PEND_NONE;
            n_acc     = '0;
            if (r_pending != utf8l_pkg::PEND_NONE) begin
                // broken sequence: '?' then the end marker
                push.num               = utf8l_pkg::NUM_TWO;
                push.first.last_of_run = 1'b0;
            end else begin
                push.num   = utf8l_pkg::NUM_ONE;
                push.first = '{char_code: 8'h00, is_end: 1'b1, last_of_run: 1'b1};
            end
        end else if (r_pending == utf8l_pkg::PEND_NONE) begin
            priority if (!r_in_byte[7]) begin
                push.num             = utf8l_pkg::NUM_ONE;
                push.first.char_code = r_in_byte;
            end else if ((r_in_byte & utf8l_pkg::LEAD2_MASK) == utf8l_pkg::LEAD2_PAT) begin
                n_pending = 2'd1;
                n_acc     = {16'd0, r_in_byte[4:0]};
            end else if ((r_in_byte & utf8l_pkg::LEAD3_MASK) == utf8l_pkg::LEAD3_PAT) begin
                n_pending = 2'd2;
                n_acc     = {17'd0, r_in_byte[3:0]};
            end else if ((r_in_byte & utf8l_pkg::LEAD4_MASK) == utf8l_pkg::LEAD4_PAT) begin
                n_pending = 2'd3;
                n_acc     = {18'd0, r_in_byte[2:0]};
            end else begin
                push.num = utf8l_pkg::NUM_ONE;
            end
        end else if ((r_in_byte & utf8l_pkg::CONT_MASK) != utf8l_pkg::CONT_PAT) begin
            // bad continuation: drop the sequence, the byte is consumed
            n_pending = utf8l_pkg::PEND_NONE;
            n_acc     = '0;
            push.num  = utf8l_pkg::NUM_ONE;
        end else begin
            n_pending = dec_pending;
            if (dec_pending != utf8l_pkg::PEND_NONE) begin
                n_acc = shifted;
            end else begin
                n_acc                = '0;
                push.num             = utf8l_pkg::NUM_ONE;
                push.first.char_code = utf8l_pkg::map_codepoint(shifted);
            end
        end
        if (!consume) begin
            push.num = utf8l_pkg::NUM_NONE;
        end
    end

    // Sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= utf8l_pkg::PEND_NONE;
            r_acc     <= '0;
        end else if (consume) begin
            r_pending <= n_pending;
            r_acc     <= n_acc;
        end
    end

    assign o_push = push;

endmodule

>>> rtl/core/utf8l_rq.sv
// Three-entry result queue: takes up to two results per cycle, presents the head.
module utf8l_rq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  utf8l_pkg::t_push    i_push,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output utf8l_pkg::t_result  o_head
);

    utf8l_pkg::t_result              r_q [utf8l_pkg::QUEUE_DEPTH];
    utf8l_pkg::t_result              n_q [utf8l_pkg::QUEUE_DEPTH];
    logic [utf8l_pkg::QCNT_W-1:0]    r_count;
    logic [utf8l_pkg::QCNT_W-1:0]    n_count;
    logic [utf8l_pkg::QCNT_W-1:0]    cnt_after;
    logic                            pop;

    assign o_valid = (r_count != '0);
    assign o_head  = r_q[0];
    assign pop     = o_valid && i_ready;
    // room for a two-result word
    assign o_room  = (r_count <= utf8l_pkg::QCNT_W'(utf8l_pkg::QUEUE_DEPTH - 2));

    assign cnt_after = r_count - utf8l_pkg::QCNT_W'(pop);
    assign n_count   = cnt_after + utf8l_pkg::QCNT_W'(i_push.num);

    // Shift down on pop, then write new results behind the survivors
    always_comb begin
        for (int i = 0; i < utf8l_pkg::QUEUE_DEPTH; i++) begin
            if (pop && (i < utf8l_pkg::QUEUE_DEPTH - 1)) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (i_push.num != utf8l_pkg::NUM_NONE &&
                utf8l_pkg::QCNT_W'(i) == cnt_after) begin
                n_q[i] = i_push.first;
            end
            if (i_push.num == utf8l_pkg::NUM_TWO &&
                utf8l_pkg::QCNT_W'(i) == cnt_after + utf8l_pkg::QCNT_W'(1)) begin
                n_q[i] = i_push.second;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < utf8l_pkg::QUEUE_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/core/utf8_to_latin1_decoder_top.sv
// UTF-8 to Latin-1 decoder top level: one byte word in, display code words out.
// Takes one byte word per cycle. A byte is registered in the input register, then
// decoded against the pending sequence state once the queue has room, and its
// results land in a three-entry result queue whose head drives the output. With
// the queue empty, a result passes the input register and then the queue register
// on its way to the output. ASCII bytes, completed sequences and invalid bytes give
// one result, lead and middle bytes give none, an end word outside a sequence gives
// the end marker, and an end word inside a sequence gives two ('?' then the end
// marker). The input keeps accepting every cycle as long as the queue holds at most
// one waiting result; the queue size sets how much output stall is absorbed.
module utf8_to_latin1_decoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    utf8l_in_if.sink           i_in,
    utf8l_out_if.source        o_out
);

    utf8l_pkg::t_push   push;
    utf8l_pkg::t_result head;
    logic               room;

    // Byte decode with sequence state
    utf8l_dec u_dec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_data_byte   (i_in.data_byte),
        .i_end_of_data (i_in.end_of_data),
        .i_room        (room),
        .o_push        (push)
    );

    // Result queue toward the output
    utf8l_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_head  (head)
    );

    assign o_out.char_code   = head.char_code;
    assign o_out.is_end      = head.is_end;
    assign o_out.last_of_run = head.last_of_run;

endmodule

>>> rtl/core/utf8l_chk.sv
// Port-level checker for the decoder output, bound to the top level.
module utf8l_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_char_code,
    input logic       i_is_end,
    input logic       i_last_of_run
);

    // A stalled output word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_char_code) &&
            $stable(i_is_end) && $stable(i_last_of_run))
        else $error("output word changed while stalled");

    // End marker carries a zero code and closes its run
    a_end_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_is_end |-> i_char_code == 8'h00 && i_last_of_run)
        else $error("end marker malformed");

    // Only the replacement ahead of an end marker is not last of its run
    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last_of_run |-> i_char_code == utf8l_pkg::REPL_CODE && !i_is_end)
        else $error("unexpected non-final result");

    // After a non-final result is taken, the next word shown is the end marker
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last_of_run |=> i_valid && i_is_end)
        else $error("end marker does not follow replacement");

endmodule

bind utf8_to_latin1_decoder_top utf8l_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_char_code   (o_out.char_code),
    .i_is_end      (o_out.is_end),
    .i_last_of_run (o_out.last_of_run)
);

>>> sim/utf8l_tb_checker.sv
`timescale 1ns / 100ps
// Checker for the UTF-8 to Latin-1 decoder: byte decoding predictor and output word compare.
module utf8l_tb_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    utf8l_in_if   i_in,
    utf8l_out_if  i_out,
    output int    o_mismatch_count,
    output int    o_results_waiting
);
    import utf8l_pkg::*;

    // Decoder state as seen from the byte stream
    logic [1:0]      pend_bytes = PEND_NONE;
    logic [CP_W-1:0] cp_acc     = '0;

    // Display code words still owed by the block, oldest first
    t_result expected_codes[$];
    int      mismatches = 0;

    // Display code for one complete code point
    function automatic logic [7:0] latin1_code(input logic [CP_W-1:0] cp);
        if (cp == 21'h0000AD) begin
            return SPACE_CODE;      // soft hyphen shows as a space
        end
        if (cp >= 21'h0000A0 && cp <= 21'h0000FF) begin
            return cp[7:0];
        end
        case (cp)
            21'h002018, 21'h002019, 21'h00201A, 21'h00201B: return APOS_CODE;
            21'h00201C, 21'h00201D, 21'h00201E, 21'h00201F: return QUOTE_CODE;
            21'h002013, 21'h002014:                         return DASH_CODE;
            21'h002026:                                     return ELLIP_CODE;
            21'h002002, 21'h002003, 21'h002009:             return SPACE_CODE;
            default:                                        return REPL_CODE;
        endcase
    endfunction

    task automatic owe_code(input logic [7:0] code, input logic at_end, input logic last);
        expected_codes.push_back('{char_code: code, is_end: at_end, last_of_run: last});
    endtask

    // Advance the decoder by one accepted byte word and queue what it emits
    task automatic decode_word(input logic [7:0] b, input logic eod);
        if (eod) begin
            if (pend_bytes != PEND_NONE) begin
                owe_code(REPL_CODE, 1'b0, 1'b0);    // sequence cut short
            end
            owe_code(8'h00, 1'b1, 1'b1);
            pend_bytes = PEND_NONE;
            cp_acc     = '0;
        end else if (pend_bytes == PEND_NONE) begin
            if (!b[7]) begin
                owe_code(b, 1'b0, 1'b1);
            end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
                pend_bytes = 2'd1;
                cp_acc     = {{(CP_W-5){1'b0}}, b[4:0]};
            end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
                pend_bytes = 2'd2;
                cp_acc     = {{(CP_W-4){1'b0}}, b[3:0]};
            end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
                pend_bytes = 2'd3;
                cp_acc     = {{(CP_W-3){1'b0}}, b[2:0]};
            end else begin
                owe_code(REPL_CODE, 1'b0, 1'b1);    // stray continuation or bad lead
            end
        end else if ((b & CONT_MASK) != CONT_PAT) begin
            // bad continuation: drop the sequence, the byte is swallowed
            pend_bytes = PEND_NONE;
            cp_acc     = '0;
            owe_code(REPL_CODE, 1'b0, 1'b1);
        end else begin
            cp_acc     = {cp_acc[CP_W-7:0], b[5:0]};
            pend_bytes = pend_bytes - 2'd1;
            if (pend_bytes == PEND_NONE) begin
                owe_code(latin1_code(cp_acc), 1'b0, 1'b1);
                cp_acc = '0;
            end
        end
    endtask

    // Both channels sampled at the clock edge, before the block updates
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            pend_bytes = PEND_NONE;
            cp_acc     = '0;
            expected_codes.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                decode_word(i_in.data_byte, i_in.end_of_data);
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_codes.size() == 0) begin
                    $error("unexpected word: char_code %0h is_end %0b last_of_run %0b",
                           i_out.char_code, i_out.is_end, i_out.last_of_run);
                    mismatches++;
                end else begin
                    want = expected_codes.pop_front();
                    if (i_out.char_code !== want.char_code) begin
                        $error("char_code: expected %0h, actual %0h",
                               want.char_code, i_out.char_code);
                        mismatches++;
                    end
                    if (i_out.is_end !== want.is_end) begin
                        $error("is_end: expected %0b, actual %0b", want.is_end, i_out.is_end);
                        mismatches++;
                    end
                    if (i_out.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last_of_run, i_out.last_of_run);
                        mismatches++;
                    end
                end
            end
        end
        o_mismatch_count  <= mismatches;
        o_results_waiting <= expected_codes.size();
    end

endmodule

>>> sim/utf8_to_latin1_decoder_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the UTF-8 to Latin-1 decoder: clock, reset, byte stimulus and verdict.
module utf8_to_latin1_decoder_top_tb;
    import utf8l_pkg::*;

    logic i_clk;
    logic i_rst_n;

    utf8l_in_if  in_ch();
    utf8l_out_if out_ch();

    int mismatch_count;
    int results_waiting;
    int words_sent = 0;

    utf8_to_latin1_decoder_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    utf8l_tb_checker checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in              (in_ch),
        .i_out             (out_ch),
        .o_mismatch_count  (mismatch_count),
        .o_results_waiting (results_waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Offer one byte word, with random gaps, and hold it until taken
    task automatic send_word(input logic [7:0] b, input logic eod);
        // no gaps in the middle stretch of the stream
        while ((words_sent < 600 || words_sent > 1000) && $urandom_range(0, 99) < 7) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.end_of_data <= eod;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    // Send the first count bytes of the len-byte encoding of cp
    task automatic send_utf8(input logic [CP_W-1:0] cp, input int len, input int count);
        logic [7:0] enc [0:3];
        enc[3] = 8'h00;
        case (len)
            4: begin
                enc[0] = LEAD4_PAT | {5'b0, cp[20:18]};
                enc[1] = CONT_PAT  | {2'b0, cp[17:12]};
                enc[2] = CONT_PAT  | {2'b0, cp[11:6]};
                enc[3] = CONT_PAT  | {2'b0, cp[5:0]};
            end
            3: begin
                enc[0] = LEAD3_PAT | {4'b0, cp[15:12]};
                enc[1] = CONT_PAT  | {2'b0, cp[11:6]};
                enc[2] = CONT_PAT  | {2'b0, cp[5:0]};
            end
            default: begin
                enc[0] = LEAD2_PAT | {3'b0, cp[10:6]};
                enc[1] = CONT_PAT  | {2'b0, cp[5:0]};
                enc[2] = 8'h00;
            end
        endcase
        for (int k = 0; k < count; k++) begin
            send_word(enc[k], 1'b0);
        end
    endtask

    // Receiver: random stalls, a quiet stretch, and two long hold-offs
    initial begin
        int cycle;
        int hold_left;
        cycle     = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cycle++;
            if (cycle == 400 || cycle == 1500) begin
                hold_left = 120;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if ((cycle < 800 || cycle > 1300) && $urandom_range(0, 99) < 7) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict
    initial begin
        // {end_of_data, data_byte}
        logic [8:0] directed_words [0:23] = '{
            9'h000, 9'h07F,                     // ASCII extremes
            9'h0C2, 9'h0AD,                     // soft hyphen
            9'h0E2, 9'h080, 9'h098,             // left single quote
            9'h0E2, 9'h080, 9'h0A6,             // ellipsis
            9'h0F0, 9'h09F, 9'h098, 9'h080,     // four-byte, unmapped
            9'h080, 9'h0FF,                     // invalid leads
            9'h0C3, 9'h041,                     // bad continuation swallows 'A'
            9'h0C1, 9'h081,                     // overlong 'A'
            9'h0E2, 9'h080, 9'h1A5,             // end inside a sequence
            9'h15A                              // plain end
        };
        logic [CP_W-1:0] punct_points [0:15] = '{
            21'h2013, 21'h2014, 21'h2018, 21'h2019, 21'h201A, 21'h201B,
            21'h201C, 21'h201D, 21'h201E, 21'h201F, 21'h2026, 21'h2002,
            21'h2003, 21'h2009, 21'h2012, 21'h2027
        };
        logic [CP_W-1:0] cp;
        logic [7:0]      b;
        int              pick;
        int              len;

        in_ch.valid       <= 1'b0;
        in_ch.data_byte   <= 8'h00;
        in_ch.end_of_data <= 1'b0;
        i_rst_n           <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_words[i]) begin
            send_word(directed_words[i][7:0], directed_words[i][8]);
        end

        // Mostly well-formed text, with noise, broken sequences and end words
        while (words_sent < 1550) begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                send_word(8'($urandom_range(0, 127)), 1'b0);
            end else if (pick < 50) begin
                cp = $urandom_range(0, 1) ? CP_W'($urandom_range(8'hA0, 8'hFF))
                                          : CP_W'($urandom_range(0, 11'h7FF));
                send_utf8(cp, 2, 2);
            end else if (pick < 70) begin
                cp = ($urandom_range(0, 9) < 6) ? punct_points[4'($urandom_range(0, 15))]
                                                 : CP_W'($urandom_range(0, 16'hFFFF));
                send_utf8(cp, 3, 3);
            end else if (pick < 78) begin
                send_utf8(CP_W'($urandom_range(0, 21'h1FFFFF)), 4, 4);
            end else if (pick < 86) begin
                send_word(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 93) begin
                // sequence broken by a byte that is not a continuation
                len = $urandom_range(2, 4);
                send_utf8(CP_W'($urandom_range(0, 21'h1FFFFF)), len,
                          $urandom_range(1, len - 1));
                b = 8'($urandom_range(0, 255));
                if (b[7:6] == 2'b10) begin
                    b[7] = 1'b0;
                end
                send_word(b, 1'b0);
            end else if (pick < 97) begin
                len = $urandom_range(2, 4);
                send_utf8(CP_W'($urandom_range(0, 21'h1FFFFF)), len,
                          $urandom_range(1, len - 1));
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
        end
        send_word(8'($urandom_range(0, 255)), 1'b1);
        in_ch.valid <= 1'b0;

        // Drain, then give the block time to show any stray word
        do begin
            @(posedge i_clk);
        end while (results_waiting != 0);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0 && results_waiting == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
